// ===== hdl/cvfc_pkg.sv =====
// Shared constants, codes and control/status types of the frequency calibration sweep.
package cvfc_pkg;

   localparam int STEP_COUNT_DEF  = 100;
   localparam int TABLE_DEPTH_DEF = 128;

   localparam int MODE_W  = 2;
   localparam int TIME_W  = 64;
   localparam int FREQ_W  = 32;
   localparam int VOLT_W  = 16;
   localparam int TICK_W  = 32;
   localparam int STEP_W  = 8;
   localparam int ENTRY_W = FREQ_W + VOLT_W;

   localparam logic [TICK_W-1:0]        TIMEOUT_RESET = 32'd10000000;
   localparam logic signed [VOLT_W-1:0] V_MINUS_ONE   = -16'sd16384;
   localparam logic signed [VOLT_W-1:0] V_PLUS_ONE    = 16'sd16384;

   typedef enum logic [MODE_W-1:0] {
      MODE_PERIOD  = 2'd0,
      MODE_REQUEST = 2'd1,
      MODE_CANCEL  = 2'd2,
      MODE_IGNORE  = 2'd3
   } mode_type;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_DECIDE,
      ST_SV_WAIT,
      ST_INS_BEGIN,
      ST_INS_WAIT,
      ST_INS_CHK,
      ST_SHF_INIT,
      ST_SHF_WAIT,
      ST_SHF_WR,
      ST_PUT,
      ST_LK_BEGIN,
      ST_LK_WAIT,
      ST_LK_CHK,
      ST_LK_MUL,
      ST_LK_DIV,
      ST_LK_DIVW,
      ST_PUSH
   } state_type;

   typedef enum logic [4:0] {
      OP_NONE,
      OP_CAPTURE,
      OP_SV_START,
      OP_SV_END,
      OP_POS_ZERO,
      OP_POS_NEXT,
      OP_IDX_TOP,
      OP_IDX_DEC,
      OP_SHF_WR,
      OP_PUT,
      OP_LK_INIT,
      OP_LK_ADV,
      OP_LK_HIT,
      OP_LK_MUL,
      OP_LK_DIV,
      OP_LK_END,
      OP_LK_MISS,
      OP_PUSH
   } dp_op_type;

   typedef struct packed {
      dp_op_type         op;
      logic              set_latest;
      logic              drive_m1;
      logic              gate_close;
      logic              lst_now;
      logic              lst_clear;
      logic              count_clear;
      logic              held_m1;
      logic              sweep_active;
      logic [STEP_W-1:0] step;
   } cmd_type;

   typedef struct packed {
      mode_type mode;
      logic     sample_valid;
      logic     freq_zero;
      logic     latest_zero;
      logic     timeout;
      logic     count_zero;
      logic     count_full;
      logic     pos_at_count;
      logic     key_eq;
      logic     key_gt;
      logic     idx_zero;
      logic     idx_at_pos;
      logic     lk_hit;
      logic     lk_last;
      logic     div_busy;
      logic     rsp_free;
   } status_type;

endpackage

// ===== hdl/cvfc_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module cvfc_ram #(
   parameter int WIDTH = 48,
   parameter int DEPTH = 128
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// ===== hdl/cvfc_dp.sv =====
// Datapath: item registers, sorted table, multiplier, divider and result register.
module cvfc_dp #(
   parameter int STEP_COUNT  = cvfc_pkg::STEP_COUNT_DEF,
   parameter int TABLE_DEPTH = cvfc_pkg::TABLE_DEPTH_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  cvfc_pkg::cmd_type                   cmd,
   output cvfc_pkg::status_type                status,
   input  logic [cvfc_pkg::MODE_W-1:0]         req_mode,
   input  logic [cvfc_pkg::TIME_W-1:0]         req_now,
   input  logic                                req_sample_valid,
   input  logic [cvfc_pkg::FREQ_W-1:0]         req_frequency,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic                                rsp_voltage_driven,
   output logic signed [cvfc_pkg::VOLT_W-1:0]  rsp_voltage,
   output logic                                rsp_gate_driven,
   output logic                                rsp_gate_open,
   output logic                                rsp_busy_calibrating,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [cvfc_pkg::TICK_W-1:0]         csr_timeout_ticks
);

   localparam int AW    = $clog2(TABLE_DEPTH);
   localparam int CW    = $clog2(TABLE_DEPTH + 1);
   localparam int CW1   = CW + 1;
   localparam int HALF  = STEP_COUNT / 2;
   localparam int DIV_N = 49;
   localparam int DCW   = $clog2(DIV_N);
   localparam int FW    = cvfc_pkg::FREQ_W;
   localparam int VW    = cvfc_pkg::VOLT_W;
   localparam int SUM_W = DIV_N + 2;

   cvfc_pkg::mode_type     mode_ff;
   logic [cvfc_pkg::TIME_W-1:0] now_ff, lst_ff, lst_in;
   logic                   sv_ff;
   logic [FW-1:0]          freq_ff, latest_ff, latest_in;
   logic signed [VW-1:0]   held_ff, held_in;
   logic [CW-1:0]          count_ff, count_in;
   logic [AW-1:0]          idx_ff, idx_in, pos_ff, pos_in;
   logic [FW-1:0]          pf_ff, pf_in, ef_ff, ef_in, den_ff, den_in;
   logic signed [VW-1:0]   pv_ff, pv_in, ev_ff, ev_in, base_ff, base_in;
   logic signed [DIV_N:0]  prod_ff, prod_in;
   logic                   neg_ff, neg_in;
   logic                   div_busy_ff, div_busy_in;
   logic [DCW-1:0]         div_cnt_ff, div_cnt_in;
   logic [FW:0]            rem_ff, rem_in;
   logic [DIV_N-1:0]       quo_ff, quo_in;
   logic [cvfc_pkg::TICK_W-1:0] timeout_ff;
   logic                   vd_ff, vd_in, gd_ff, gd_in, g_ff, g_in;
   logic signed [VW-1:0]   v_ff, v_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic                   rsp_vd_ff, rsp_gd_ff, rsp_g_ff, rsp_busy_ff;
   logic signed [VW-1:0]   rsp_v_ff;

   logic                   ram_we;
   logic [AW-1:0]          ram_waddr;
   logic [cvfc_pkg::ENTRY_W-1:0] ram_wdata, ram_rdata;
   logic [FW-1:0]          rkey;
   logic signed [VW-1:0]   rval;
   logic [CW-1:0]          cnt_m1;
   logic signed [VW:0]     dv;
   logic signed [FW:0]     df;
   logic signed [DIV_N:0]  prod_abs;
   logic [FW:0]            rem_sh;
   logic signed [SUM_W-1:0] sum, qs;
   logic signed [VW-1:0]   sat_v;
   logic                   div_load;
   logic [DIV_N-1:0]       div_num;
   wire signed [VW-1:0]    step_volt_rom [256];

   // step voltage per step index, rounded to nearest and saturated at +1.0
   for (genvar g = 0; g < 256; g++) begin : g_step_volt
      localparam int SV_Q = (g * int'(cvfc_pkg::V_PLUS_ONE) + HALF / 2) / HALF
                            + int'(cvfc_pkg::V_MINUS_ONE);
      assign step_volt_rom[g] = VW'((SV_Q > int'(cvfc_pkg::V_PLUS_ONE)) ?
                                    int'(cvfc_pkg::V_PLUS_ONE) : SV_Q);
   end

   cvfc_ram #(
      .WIDTH (cvfc_pkg::ENTRY_W),
      .DEPTH (TABLE_DEPTH)
   ) u_table (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .raddr (idx_ff),
      .rdata (ram_rdata)
   );

   assign rkey   = ram_rdata[cvfc_pkg::ENTRY_W-1:VW];
   assign rval   = signed'(ram_rdata[VW-1:0]);
   assign cnt_m1 = count_ff - CW'(1);

   // table writes: shift one entry up, or place the new pair
   always_comb begin
      ram_we    = 1'b0;
      ram_waddr = pos_ff;
      ram_wdata = {freq_ff, held_ff};
      if (cmd.op == cvfc_pkg::OP_SHF_WR) begin
         ram_we    = 1'b1;
         ram_waddr = idx_ff + AW'(1);
         ram_wdata = ram_rdata;
      end else if (cmd.op == cvfc_pkg::OP_PUT) begin
         ram_we = 1'b1;
      end
   end

   // saturated base plus signed quotient
   always_comb begin
      qs  = signed'({2'b00, quo_ff});
      sum = SUM_W'(base_ff) + (neg_ff ? -qs : qs);
      if (sum < SUM_W'(cvfc_pkg::V_MINUS_ONE)) begin
         sat_v = cvfc_pkg::V_MINUS_ONE;
      end else if (sum > SUM_W'(cvfc_pkg::V_PLUS_ONE)) begin
         sat_v = cvfc_pkg::V_PLUS_ONE;
      end else begin
         sat_v = sum[VW-1:0];
      end
   end

   assign dv       = VW'(0) + ((VW+1)'(ev_ff) - (VW+1)'(pv_ff));
   assign df       = signed'({1'b0, latest_ff - pf_ff});
   assign prod_abs = prod_ff[DIV_N] ? -prod_ff : prod_ff;
   assign rem_sh   = {rem_ff[FW-1:0], quo_ff[DIV_N-1]};

   always_comb begin
      latest_in    = latest_ff;
      lst_in       = lst_ff;
      held_in      = held_ff;
      count_in     = count_ff;
      idx_in       = idx_ff;
      pos_in       = pos_ff;
      pf_in        = pf_ff;
      pv_in        = pv_ff;
      ef_in        = ef_ff;
      ev_in        = ev_ff;
      prod_in      = prod_ff;
      den_in       = den_ff;
      base_in      = base_ff;
      neg_in       = neg_ff;
      vd_in        = vd_ff;
      v_in         = v_ff;
      gd_in        = gd_ff;
      g_in         = g_ff;
      div_load     = 1'b0;
      div_num      = '0;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;

      if (cmd.set_latest) begin
         latest_in = freq_ff;
      end
      if (cmd.lst_now) begin
         lst_in = now_ff;
      end
      if (cmd.lst_clear) begin
         lst_in = '0;
      end
      if (cmd.count_clear) begin
         count_in = '0;
      end
      if (cmd.held_m1) begin
         held_in = cvfc_pkg::V_MINUS_ONE;
      end
      if (cmd.drive_m1) begin
         vd_in = 1'b1;
         v_in  = cvfc_pkg::V_MINUS_ONE;
      end
      if (cmd.gate_close) begin
         gd_in = 1'b1;
         g_in  = 1'b0;
      end

      case (cmd.op)
         cvfc_pkg::OP_CAPTURE: begin
            vd_in = 1'b0;
            v_in  = '0;
            gd_in = 1'b0;
            g_in  = 1'b0;
         end
         cvfc_pkg::OP_SV_END: begin
            held_in = step_volt_rom[cmd.step];
            vd_in   = 1'b1;
            v_in    = step_volt_rom[cmd.step];
            gd_in   = 1'b1;
            g_in    = 1'b1;
         end
         cvfc_pkg::OP_POS_ZERO: pos_in = '0;
         cvfc_pkg::OP_POS_NEXT: pos_in = idx_ff + AW'(1);
         cvfc_pkg::OP_IDX_TOP:  idx_in = cnt_m1[AW-1:0];
         cvfc_pkg::OP_IDX_DEC:  idx_in = idx_ff - AW'(1);
         cvfc_pkg::OP_SHF_WR: begin
            if (idx_ff != pos_ff) begin
               idx_in = idx_ff - AW'(1);
            end
         end
         cvfc_pkg::OP_PUT: count_in = count_ff + CW'(1);
         cvfc_pkg::OP_LK_INIT: begin
            idx_in = '0;
            pf_in  = '0;
            pv_in  = cvfc_pkg::V_MINUS_ONE;
         end
         cvfc_pkg::OP_LK_ADV: begin
            pf_in  = rkey;
            pv_in  = rval;
            idx_in = idx_ff + AW'(1);
         end
         cvfc_pkg::OP_LK_HIT: begin
            ef_in = rkey;
            ev_in = rval;
         end
         cvfc_pkg::OP_LK_MUL: begin
            prod_in = dv * df;
            den_in  = ef_ff - pf_ff;
         end
         cvfc_pkg::OP_LK_DIV: begin
            div_load = 1'b1;
            div_num  = prod_abs[DIV_N-1:0] + DIV_N'(den_ff >> 1);
            neg_in   = prod_ff[DIV_N];
            base_in  = pv_ff;
         end
         cvfc_pkg::OP_LK_END: begin
            vd_in = 1'b1;
            v_in  = sat_v;
         end
         cvfc_pkg::OP_LK_MISS: begin
            vd_in = 1'b1;
            v_in  = cvfc_pkg::V_MINUS_ONE;
         end
         cvfc_pkg::OP_PUSH: rsp_valid_in = 1'b1;
         default: begin
         end
      endcase
   end

   // restoring divider, one quotient bit a cycle
   always_comb begin
      div_busy_in = div_busy_ff;
      div_cnt_in  = div_cnt_ff;
      rem_in      = rem_ff;
      quo_in      = quo_ff;
      if (div_load) begin
         div_busy_in = 1'b1;
         div_cnt_in  = DCW'(DIV_N - 1);
         rem_in      = '0;
         quo_in      = div_num;
      end else if (div_busy_ff) begin
         if (rem_sh >= {1'b0, den_ff}) begin
            rem_in = rem_sh - {1'b0, den_ff};
            quo_in = {quo_ff[DIV_N-2:0], 1'b1};
         end else begin
            rem_in = rem_sh;
            quo_in = {quo_ff[DIV_N-2:0], 1'b0};
         end
         if (div_cnt_ff == '0) begin
            div_busy_in = 1'b0;
         end else begin
            div_cnt_in = div_cnt_ff - DCW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         latest_ff    <= '0;
         lst_ff       <= '0;
         held_ff      <= cvfc_pkg::V_MINUS_ONE;
         count_ff     <= '0;
         div_busy_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         timeout_ff   <= cvfc_pkg::TIMEOUT_RESET;
      end else begin
         latest_ff    <= latest_in;
         lst_ff       <= lst_in;
         held_ff      <= held_in;
         count_ff     <= count_in;
         div_busy_ff  <= div_busy_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid) begin
            timeout_ff <= csr_timeout_ticks;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.op == cvfc_pkg::OP_CAPTURE) begin
         mode_ff <= cvfc_pkg::mode_type'(req_mode);
         now_ff  <= req_now;
         sv_ff   <= req_sample_valid;
         freq_ff <= req_frequency;
      end
      if (cmd.op == cvfc_pkg::OP_PUSH) begin
         rsp_vd_ff   <= vd_ff;
         rsp_v_ff    <= v_ff;
         rsp_gd_ff   <= gd_ff;
         rsp_g_ff    <= g_ff;
         rsp_busy_ff <= cmd.sweep_active;
      end
      idx_ff     <= idx_in;
      pos_ff     <= pos_in;
      pf_ff      <= pf_in;
      pv_ff      <= pv_in;
      ef_ff      <= ef_in;
      ev_ff      <= ev_in;
      prod_ff    <= prod_in;
      den_ff     <= den_in;
      base_ff    <= base_in;
      neg_ff     <= neg_in;
      div_cnt_ff <= div_cnt_in;
      rem_ff     <= rem_in;
      quo_ff     <= quo_in;
      vd_ff      <= vd_in;
      v_ff       <= v_in;
      gd_ff      <= gd_in;
      g_ff       <= g_in;
   end

   always_comb begin
      status.mode         = mode_ff;
      status.sample_valid = sv_ff;
      status.freq_zero    = freq_ff == '0;
      status.latest_zero  = latest_ff == '0;
      status.timeout      = (now_ff - lst_ff) > cvfc_pkg::TIME_W'(timeout_ff);
      status.count_zero   = count_ff == '0;
      status.count_full   = count_ff == CW'(TABLE_DEPTH);
      status.pos_at_count = CW'(pos_ff) == count_ff;
      status.key_eq       = rkey == freq_ff;
      status.key_gt       = rkey > freq_ff;
      status.idx_zero     = idx_ff == '0;
      status.idx_at_pos   = idx_ff == pos_ff;
      status.lk_hit       = (rkey > latest_ff) && (pf_ff < rkey);
      status.lk_last      = (CW1'(idx_ff) + CW1'(1)) >= CW1'(count_ff);
      status.div_busy     = div_busy_ff;
      status.rsp_free     = !rsp_valid_ff || rsp_ready;
   end

   assign csr_ready            = 1'b1;
   assign rsp_valid            = rsp_valid_ff;
   assign rsp_voltage_driven   = rsp_vd_ff;
   assign rsp_voltage          = rsp_v_ff;
   assign rsp_gate_driven      = rsp_gd_ff;
   assign rsp_gate_open        = rsp_g_ff;
   assign rsp_busy_calibrating = rsp_busy_ff;

endmodule

// ===== hdl/cvfc_ctrl.sv =====
// Controller: sweep state flags and the sequencer that drives the datapath.
module cvfc_ctrl #(
   parameter int STEP_COUNT = cvfc_pkg::STEP_COUNT_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  cvfc_pkg::status_type status,
   output cvfc_pkg::cmd_type    cmd
);

   localparam int SW = cvfc_pkg::STEP_W;

   cvfc_pkg::state_type state_ff, state_in;
   logic          run_ff, run_in, active_ff, active_in, await_ff, await_in, seen_ff, seen_in;
   logic [SW-1:0] step_ff, step_in;

   logic is_period, d_start, d_end_step, d_tmo, d_sv, d_ins, d_cancel, d_stop;
   logic run_after, d_lookup;

   // decision for one word, valid in the decide state
   always_comb begin
      is_period  = status.mode == cvfc_pkg::MODE_PERIOD;
      d_start    = is_period && run_ff && !active_ff;
      d_end_step = is_period && run_ff && (step_ff > SW'(STEP_COUNT));
      d_tmo      = is_period && run_ff && !d_end_step && active_ff && status.timeout;
      d_sv       = is_period && run_ff && !d_end_step && !d_tmo && !await_ff
                   && status.sample_valid && status.freq_zero;
      d_ins      = is_period && run_ff && !d_end_step && !d_tmo && await_ff
                   && status.sample_valid;
      d_cancel   = is_period && !run_ff && (step_ff != '0);
      d_stop     = d_end_step || d_tmo || d_cancel;
      case (status.mode)
         cvfc_pkg::MODE_PERIOD:  run_after = run_ff && !d_stop;
         cvfc_pkg::MODE_REQUEST: run_after = 1'b1;
         cvfc_pkg::MODE_CANCEL:  run_after = 1'b0;
         default:                run_after = run_ff;
      endcase
      d_lookup   = is_period && !run_after && (seen_ff || status.sample_valid);
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         cvfc_pkg::ST_IDLE: begin
            if (req_valid) state_in = cvfc_pkg::ST_DECIDE;
         end
         cvfc_pkg::ST_DECIDE: begin
            if (d_sv)          state_in = cvfc_pkg::ST_SV_WAIT;
            else if (d_ins)    state_in = cvfc_pkg::ST_INS_BEGIN;
            else if (d_lookup) state_in = cvfc_pkg::ST_LK_BEGIN;
            else               state_in = cvfc_pkg::ST_PUSH;
         end
         cvfc_pkg::ST_SV_WAIT: begin
            if (!status.div_busy) state_in = cvfc_pkg::ST_PUSH;
         end
         cvfc_pkg::ST_INS_BEGIN: begin
            if (status.count_full)      state_in = cvfc_pkg::ST_PUSH;
            else if (status.count_zero) state_in = cvfc_pkg::ST_PUT;
            else                        state_in = cvfc_pkg::ST_INS_WAIT;
         end
         cvfc_pkg::ST_INS_WAIT: state_in = cvfc_pkg::ST_INS_CHK;
         cvfc_pkg::ST_INS_CHK: begin
            if (status.key_eq)                         state_in = cvfc_pkg::ST_PUSH;
            else if (status.key_gt && !status.idx_zero) state_in = cvfc_pkg::ST_INS_WAIT;
            else                                       state_in = cvfc_pkg::ST_SHF_INIT;
         end
         cvfc_pkg::ST_SHF_INIT: begin
            if (status.pos_at_count) state_in = cvfc_pkg::ST_PUT;
            else                     state_in = cvfc_pkg::ST_SHF_WAIT;
         end
         cvfc_pkg::ST_SHF_WAIT: state_in = cvfc_pkg::ST_SHF_WR;
         cvfc_pkg::ST_SHF_WR: begin
            if (status.idx_at_pos) state_in = cvfc_pkg::ST_PUT;
            else                   state_in = cvfc_pkg::ST_SHF_WAIT;
         end
         cvfc_pkg::ST_PUT: state_in = cvfc_pkg::ST_PUSH;
         cvfc_pkg::ST_LK_BEGIN: begin
            if (status.latest_zero || active_ff || status.count_zero) begin
               state_in = cvfc_pkg::ST_PUSH;
            end else begin
               state_in = cvfc_pkg::ST_LK_WAIT;
            end
         end
         cvfc_pkg::ST_LK_WAIT: state_in = cvfc_pkg::ST_LK_CHK;
         cvfc_pkg::ST_LK_CHK: begin
            if (status.lk_hit)       state_in = cvfc_pkg::ST_LK_MUL;
            else if (status.lk_last) state_in = cvfc_pkg::ST_PUSH;
            else                     state_in = cvfc_pkg::ST_LK_WAIT;
         end
         cvfc_pkg::ST_LK_MUL: state_in = cvfc_pkg::ST_LK_DIV;
         cvfc_pkg::ST_LK_DIV: state_in = cvfc_pkg::ST_LK_DIVW;
         cvfc_pkg::ST_LK_DIVW: begin
            if (!status.div_busy) state_in = cvfc_pkg::ST_PUSH;
         end
         cvfc_pkg::ST_PUSH: begin
            if (status.rsp_free) state_in = cvfc_pkg::ST_IDLE;
         end
         default: state_in = cvfc_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      cmd              = '0;
      cmd.op           = cvfc_pkg::OP_NONE;
      cmd.step         = step_ff;
      cmd.sweep_active = active_ff;
      run_in           = run_ff;
      active_in        = active_ff;
      await_in         = await_ff;
      seen_in          = seen_ff;
      step_in          = step_ff;
      req_ready        = 1'b0;
      unique case (state_ff)
         cvfc_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) cmd.op = cvfc_pkg::OP_CAPTURE;
         end
         cvfc_pkg::ST_DECIDE: begin
            run_in = run_after;
            if (is_period && status.sample_valid) begin
               cmd.set_latest = 1'b1;
               seen_in        = 1'b1;
            end
            if (d_start) begin
               cmd.drive_m1    = 1'b1;
               cmd.gate_close  = 1'b1;
               cmd.lst_now     = 1'b1;
               cmd.count_clear = 1'b1;
               active_in       = 1'b1;
            end
            if (d_sv) begin
               cmd.op      = cvfc_pkg::OP_SV_START;
               cmd.lst_now = 1'b1;
               await_in    = 1'b1;
            end
            if (d_ins) begin
               cmd.gate_close = 1'b1;
               cmd.lst_now    = 1'b1;
               await_in       = 1'b0;
               step_in        = step_ff + SW'(1);
            end
            if (d_stop) begin
               cmd.count_clear = d_tmo || d_cancel;
               cmd.lst_clear   = 1'b1;
               cmd.held_m1     = 1'b1;
               cmd.drive_m1    = 1'b1;
               cmd.gate_close  = 1'b1;
               active_in       = 1'b0;
               await_in        = 1'b0;
               step_in         = '0;
            end
         end
         cvfc_pkg::ST_SV_WAIT: begin
            if (!status.div_busy) cmd.op = cvfc_pkg::OP_SV_END;
         end
         cvfc_pkg::ST_INS_BEGIN: begin
            if (status.count_full)      cmd.op = cvfc_pkg::OP_NONE;
            else if (status.count_zero) cmd.op = cvfc_pkg::OP_POS_ZERO;
            else                        cmd.op = cvfc_pkg::OP_IDX_TOP;
         end
         cvfc_pkg::ST_INS_WAIT: cmd.op = cvfc_pkg::OP_NONE;
         cvfc_pkg::ST_INS_CHK: begin
            if (status.key_eq)                          cmd.op = cvfc_pkg::OP_NONE;
            else if (status.key_gt && !status.idx_zero) cmd.op = cvfc_pkg::OP_IDX_DEC;
            else if (status.key_gt)                     cmd.op = cvfc_pkg::OP_POS_ZERO;
            else                                        cmd.op = cvfc_pkg::OP_POS_NEXT;
         end
         cvfc_pkg::ST_SHF_INIT: begin
            if (!status.pos_at_count) cmd.op = cvfc_pkg::OP_IDX_TOP;
         end
         cvfc_pkg::ST_SHF_WAIT: cmd.op = cvfc_pkg::OP_NONE;
         cvfc_pkg::ST_SHF_WR:   cmd.op = cvfc_pkg::OP_SHF_WR;
         cvfc_pkg::ST_PUT:      cmd.op = cvfc_pkg::OP_PUT;
         cvfc_pkg::ST_LK_BEGIN: begin
            if (status.latest_zero || active_ff || status.count_zero) begin
               cmd.op = cvfc_pkg::OP_LK_MISS;
            end else begin
               cmd.op = cvfc_pkg::OP_LK_INIT;
            end
         end
         cvfc_pkg::ST_LK_WAIT: cmd.op = cvfc_pkg::OP_NONE;
         cvfc_pkg::ST_LK_CHK: begin
            if (status.lk_hit)       cmd.op = cvfc_pkg::OP_LK_HIT;
            else if (status.lk_last) cmd.op = cvfc_pkg::OP_LK_MISS;
            else                     cmd.op = cvfc_pkg::OP_LK_ADV;
         end
         cvfc_pkg::ST_LK_MUL: cmd.op = cvfc_pkg::OP_LK_MUL;
         cvfc_pkg::ST_LK_DIV: cmd.op = cvfc_pkg::OP_LK_DIV;
         cvfc_pkg::ST_LK_DIVW: begin
            if (!status.div_busy) cmd.op = cvfc_pkg::OP_LK_END;
         end
         cvfc_pkg::ST_PUSH: begin
            if (status.rsp_free) cmd.op = cvfc_pkg::OP_PUSH;
         end
         default: cmd.op = cvfc_pkg::OP_NONE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= cvfc_pkg::ST_IDLE;
         run_ff    <= 1'b0;
         active_ff <= 1'b0;
         await_ff  <= 1'b0;
         seen_ff   <= 1'b0;
         step_ff   <= '0;
      end else begin
         state_ff  <= state_in;
         run_ff    <= run_in;
         active_ff <= active_in;
         await_ff  <= await_in;
         seen_ff   <= seen_in;
         step_ff   <= step_in;
      end
   end

   a_accept_decides: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> (state_ff == cvfc_pkg::ST_DECIDE))
      else $error("accepted word not followed by decide");
   a_step_bound: assert property (@(posedge clock) disable iff (reset)
      step_ff <= SW'(STEP_COUNT + 1))
      else $error("step index past sweep end");
   a_await_active: assert property (@(posedge clock) disable iff (reset)
      await_ff |-> active_ff)
      else $error("awaiting response without active sweep");
   a_step_active: assert property (@(posedge clock) disable iff (reset)
      (step_ff != '0) |-> active_ff)
      else $error("nonzero step without active sweep");

endmodule

// ===== hdl/cv_frequency_calibration_sweep.sv =====
// Top level of the control-voltage frequency calibration sweep.
// Each request word is one processing period; every word yields exactly one response word.
// A sweep step that drives a new voltage takes that voltage from a constant table indexed by
// the step. Storing a pair walks the sorted table through its single RAM read port, entry by
// entry. A lookup walks the table in the same way and then divides one bit a cycle.
// The response of every word waits to be pushed until the previous response is taken.
// A new request word is taken while the previous response still waits to be taken.
module cv_frequency_calibration_sweep #(
   parameter int STEP_COUNT  = cvfc_pkg::STEP_COUNT_DEF,
   parameter int TABLE_DEPTH = cvfc_pkg::TABLE_DEPTH_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [cvfc_pkg::MODE_W-1:0]         req_mode,
   input  logic [cvfc_pkg::TIME_W-1:0]         req_now,
   input  logic                                req_sample_valid,
   input  logic [cvfc_pkg::FREQ_W-1:0]         req_frequency,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic                                rsp_voltage_driven,
   output logic signed [cvfc_pkg::VOLT_W-1:0]  rsp_voltage,
   output logic                                rsp_gate_driven,
   output logic                                rsp_gate_open,
   output logic                                rsp_busy_calibrating,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [cvfc_pkg::TICK_W-1:0]         csr_timeout_ticks
);

   cvfc_pkg::cmd_type    cmd;
   cvfc_pkg::status_type status;

   cvfc_ctrl #(
      .STEP_COUNT (STEP_COUNT)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   cvfc_dp #(
      .STEP_COUNT  (STEP_COUNT),
      .TABLE_DEPTH (TABLE_DEPTH)
   ) u_dp (
      .clock                (clock),
      .reset                (reset),
      .cmd                  (cmd),
      .status               (status),
      .req_mode             (req_mode),
      .req_now              (req_now),
      .req_sample_valid     (req_sample_valid),
      .req_frequency        (req_frequency),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_voltage_driven   (rsp_voltage_driven),
      .rsp_voltage          (rsp_voltage),
      .rsp_gate_driven      (rsp_gate_driven),
      .rsp_gate_open        (rsp_gate_open),
      .rsp_busy_calibrating (rsp_busy_calibrating),
      .csr_valid            (csr_valid),
      .csr_ready            (csr_ready),
      .csr_timeout_ticks    (csr_timeout_ticks)
   );

endmodule

// ===== bench/tb_cv_frequency_calibration_sweep.sv =====
// Self-checking testbench for the frequency calibration sweep: random traffic against a predictor.
`timescale 1ns / 1ps

module tb_cv_frequency_calibration_sweep;

   localparam int STEPS = cvfc_pkg::STEP_COUNT_DEF;
   localparam int DEPTH = cvfc_pkg::TABLE_DEPTH_DEF;
   localparam longint CYCLE_LIMIT = 64'd6000000;

   typedef struct packed {
      cvfc_pkg::mode_type mode;
      logic [63:0]        now;
      logic               sample_valid;
      logic [31:0]        frequency;
   } period_type;

   typedef struct packed {
      logic        voltage_driven;
      logic [15:0] voltage;
      logic        gate_driven;
      logic        gate_open;
      logic        busy;
   } drive_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic [cvfc_pkg::MODE_W-1:0] req_mode = '0;
   logic [cvfc_pkg::TIME_W-1:0] req_now = '0;
   logic req_sample_valid = 1'b0;
   logic [cvfc_pkg::FREQ_W-1:0] req_frequency = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic rsp_voltage_driven;
   logic signed [cvfc_pkg::VOLT_W-1:0] rsp_voltage;
   logic rsp_gate_driven, rsp_gate_open, rsp_busy_calibrating;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [cvfc_pkg::TICK_W-1:0] csr_timeout_ticks = '0;

   cv_frequency_calibration_sweep DUT (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_mode(req_mode),
      .req_now(req_now), .req_sample_valid(req_sample_valid),
      .req_frequency(req_frequency),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_voltage_driven(rsp_voltage_driven), .rsp_voltage(rsp_voltage),
      .rsp_gate_driven(rsp_gate_driven), .rsp_gate_open(rsp_gate_open),
      .rsp_busy_calibrating(rsp_busy_calibrating),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_timeout_ticks(csr_timeout_ticks)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // predictor state
   logic [31:0] p_timeout;
   logic        p_run, p_active, p_waiting, p_seen;
   logic [7:0]  p_step;
   logic [63:0] p_last_time;
   logic signed [15:0] p_held;
   int          p_count;
   logic [31:0] p_latest;
   logic [31:0] cal_key [DEPTH];
   logic signed [15:0] cal_volt [DEPTH];

   period_type pending_words[$];
   drive_type  expected_drives[$];
   int  errors = 0;
   int  issued = 0;
   bit  calm = 1'b0;       // no idling in the final stretch
   bit  hold_long = 1'b0;  // receiver stalls for a long stretch
   longint cycles = 0;

   function automatic logic signed [15:0] clamp_volt(longint v);
      if (v < -16384) return -16'sd16384;
      if (v > 16384) return 16'sd16384;
      return 16'(v);
   endfunction

   function automatic logic signed [15:0] sweep_volt(logic [7:0] s);
      longint half, q;
      half = STEPS / 2;
      q = (longint'(s) * 16384 + half / 2) / half;
      return clamp_volt(q - 16384);
   endfunction

   function automatic logic signed [15:0] interpolate(logic [31:0] f);
      longint pf, pv, ef, ev, num, den, mag, q;
      pf = 0;
      pv = -16384;
      if (f == 0 || p_active) return -16'sd16384;
      for (int i = 0; i < p_count; i++) begin
         ef = cal_key[i];
         ev = cal_volt[i];
         if (ef > f && pf < ef) begin
            num = (ev - pv) * (longint'(f) - pf);
            den = ef - pf;
            mag = num < 0 ? -num : num;
            q = (mag + den / 2) / den;
            return clamp_volt(pv + (num < 0 ? -q : q));
         end
         pf = ef;
         pv = ev;
      end
      return -16'sd16384;
   endfunction

   task automatic store_pair(logic [31:0] key, logic signed [15:0] v);
      int i;
      i = 0;
      while (i < p_count && cal_key[i] < key) i++;
      if (i < p_count && cal_key[i] == key) return;
      if (p_count >= DEPTH) return;
      for (int j = p_count; j > i; j--) begin
         cal_key[j] = cal_key[j-1];
         cal_volt[j] = cal_volt[j-1];
      end
      cal_key[i] = key;
      cal_volt[i] = v;
      p_count++;
   endtask

   task automatic end_sweep(ref drive_type d);
      p_run = 1'b0;
      p_active = 1'b0;
      p_step = '0;
      p_last_time = '0;
      p_held = -16'sd16384;
      p_waiting = 1'b0;
      d.voltage_driven = 1'b1;
      d.voltage = -16'sd16384;
      d.gate_driven = 1'b1;
      d.gate_open = 1'b0;
   endtask

   task automatic predict_period(period_type w);
      drive_type d;
      d = '0;
      if (w.mode == cvfc_pkg::MODE_PERIOD) begin
         if (w.sample_valid) begin
            p_latest = w.frequency;
            p_seen = 1'b1;
         end
         if (p_run) begin
            if (!p_active) begin
               d.voltage_driven = 1'b1;
               d.voltage = -16'sd16384;
               d.gate_driven = 1'b1;
               d.gate_open = 1'b0;
               p_active = 1'b1;
               p_last_time = w.now;
               p_count = 0;
            end
            if (p_step > STEPS) begin
               end_sweep(d);
            end else if (w.now - p_last_time > 64'(p_timeout)) begin
               p_count = 0;
               end_sweep(d);
            end else if (!p_waiting) begin
               if (w.sample_valid && w.frequency == 0) begin
                  p_held = sweep_volt(p_step);
                  d.voltage_driven = 1'b1;
                  d.voltage = p_held;
                  d.gate_driven = 1'b1;
                  d.gate_open = 1'b1;
                  p_waiting = 1'b1;
                  p_last_time = w.now;
               end
            end else if (w.sample_valid) begin
               store_pair(w.frequency, p_held);
               d.gate_driven = 1'b1;
               d.gate_open = 1'b0;
               p_waiting = 1'b0;
               p_step = p_step + 8'd1;
               p_last_time = w.now;
            end
         end else if (p_step > 0) begin
            p_count = 0;
            end_sweep(d);
         end
         if (!p_run && p_seen) begin
            d.voltage_driven = 1'b1;
            d.voltage = interpolate(p_latest);
         end
      end else if (w.mode == cvfc_pkg::MODE_REQUEST) begin
         p_run = 1'b1;
      end else if (w.mode == cvfc_pkg::MODE_CANCEL) begin
         p_run = 1'b0;
      end
      d.busy = p_active;
      expected_drives.push_back(d);
   endtask

   // driver
   int req_gap = 0;
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready) issued <= issued + 1;
         if (!req_valid || req_ready) begin
            if (req_gap > 0) begin
               req_gap <= req_gap - 1;
               req_valid <= 1'b0;
            end else if (pending_words.size() > 0) begin
               period_type w;
               w = pending_words.pop_front();
               predict_period(w);
               req_valid <= 1'b1;
               req_mode <= w.mode;
               req_now <= w.now;
               req_sample_valid <= w.sample_valid;
               req_frequency <= w.frequency;
               if (!calm && $urandom_range(0, 19) == 0) req_gap <= $urandom_range(1, 16);
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // monitor
   int rsp_gap = 0;
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            drive_type got, want;
            got = {rsp_voltage_driven, rsp_voltage, rsp_gate_driven, rsp_gate_open,
                   rsp_busy_calibrating};
            if (expected_drives.size() == 0) begin
               $display("%0t unexpected word %h", $time, got);
               errors++;
            end else begin
               want = expected_drives.pop_front();
               if (got.voltage_driven !== want.voltage_driven)
                  $display("%0t voltage_driven exp %b got %b", $time,
                           want.voltage_driven, got.voltage_driven);
               if (got.voltage !== want.voltage)
                  $display("%0t voltage exp %0d got %0d", $time,
                           $signed(want.voltage), $signed(got.voltage));
               if (got.gate_driven !== want.gate_driven)
                  $display("%0t gate_driven exp %b got %b", $time,
                           want.gate_driven, got.gate_driven);
               if (got.gate_open !== want.gate_open)
                  $display("%0t gate_open exp %b got %b", $time,
                           want.gate_open, got.gate_open);
               if (got.busy !== want.busy)
                  $display("%0t busy_calibrating exp %b got %b", $time, want.busy, got.busy);
               if (got !== want) errors++;
            end
         end
         if (hold_long) begin
            rsp_ready <= 1'b0;
         end else if (rsp_gap > 0) begin
            rsp_gap <= rsp_gap - 1;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
            if (!calm && $urandom_range(0, 14) == 0) rsp_gap <= $urandom_range(1, 16);
         end
      end
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   logic [63:0] clk_now = 64'd1000;

   task automatic add_word(cvfc_pkg::mode_type m, logic sv, logic [31:0] f, logic [63:0] dt);
      period_type w;
      clk_now = clk_now + dt;
      w.mode = m;
      w.now = clk_now;
      w.sample_valid = sv;
      w.frequency = f;
      pending_words.push_back(w);
   endtask

   function automatic logic [31:0] rand_freq();
      case ($urandom_range(0, 5))
         0: return 32'hFFFF_FFFF;
         1: return $urandom_range(1, 300);
         default: return $urandom;
      endcase
   endfunction

   // one calibration run: a request, then zero/measurement pairs with some noise
   task automatic add_sweep(int steps, bit tidy, logic [63:0] dt_max);
      add_word(cvfc_pkg::MODE_REQUEST, 1'($urandom), $urandom, 0);
      for (int s = 0; s < steps; s++) begin
         if (!tidy && $urandom_range(0, 9) == 0)
            add_word(cvfc_pkg::mode_type'($urandom_range(0, 3)), 1'($urandom), rand_freq(),
                     64'($urandom_range(0, 50)));
         add_word(cvfc_pkg::MODE_PERIOD, 1'b1, 32'd0, 64'($urandom_range(0, dt_max)));
         if ($urandom_range(0, 3) == 0) add_word(cvfc_pkg::MODE_PERIOD, 1'b0, $urandom, 5);
         add_word(cvfc_pkg::MODE_PERIOD, 1'b1, rand_freq(), 64'($urandom_range(0, dt_max)));
      end
   endtask

   task automatic add_lookups(int n);
      for (int i = 0; i < n; i++)
         add_word(cvfc_pkg::MODE_PERIOD, $urandom_range(0, 4) != 0, rand_freq(),
                  64'($urandom_range(0, 1000)));
   endtask

   task automatic drain();
      while (pending_words.size() > 0 || expected_drives.size() > 0 || req_valid)
         @(posedge clock);
      repeat (300) @(posedge clock);
   endtask

   task automatic write_timeout(logic [31:0] v);
      csr_valid <= 1'b1;
      csr_timeout_ticks <= v;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      p_timeout = v;
   endtask

   initial begin
      p_timeout = cvfc_pkg::TIMEOUT_RESET;
      p_run = 0; p_active = 0; p_waiting = 0; p_seen = 0;
      p_step = 0; p_last_time = 0; p_held = -16'sd16384;
      p_count = 0; p_latest = 0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: ignored mode, lookups on empty table, cancel before the first step
      add_word(cvfc_pkg::MODE_IGNORE, 1'b1, 32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_0000);
      add_word(cvfc_pkg::MODE_PERIOD, 1'b1, 32'd0, 1);
      add_word(cvfc_pkg::MODE_PERIOD, 1'b1, 32'hFFFF_FFFF, 1);
      add_word(cvfc_pkg::MODE_REQUEST, 1'b0, 0, 0);
      add_word(cvfc_pkg::MODE_PERIOD, 1'b0, 0, 1);
      add_word(cvfc_pkg::MODE_CANCEL, 1'b0, 0, 0);
      add_word(cvfc_pkg::MODE_PERIOD, 1'b1, 32'd5, 1);
      // short sweep with duplicate keys, then cancel mid sweep
      add_word(cvfc_pkg::MODE_REQUEST, 1'b0, 0, 0);
      add_word(cvfc_pkg::MODE_PERIOD, 1'b1, 0, 1);
      add_word(cvfc_pkg::MODE_PERIOD, 1'b1, 32'h0001_0000, 1);
      add_word(cvfc_pkg::MODE_PERIOD, 1'b1, 0, 1);
      add_word(cvfc_pkg::MODE_PERIOD, 1'b1, 32'h0001_0000, 1);
      add_word(cvfc_pkg::MODE_PERIOD, 1'b1, 0, 1);
      add_word(cvfc_pkg::MODE_PERIOD, 1'b1, 32'h8000_0000, 1);
      add_word(cvfc_pkg::MODE_CANCEL, 1'b0, 0, 0);
      add_word(cvfc_pkg::MODE_PERIOD, 1'b1, 32'h4000_0000, 1);
      // a timeout gap
      add_word(cvfc_pkg::MODE_REQUEST, 1'b0, 0, 0);
      add_word(cvfc_pkg::MODE_PERIOD, 1'b1, 0, 1);
      add_word(cvfc_pkg::MODE_PERIOD, 1'b1, 32'h10, 64'd20000000);
      add_word(cvfc_pkg::MODE_PERIOD, 1'b1, 32'h10, 1);
      drain();

      // full sweep to the end, then lookups
      add_sweep(STEPS + 2, 1'b1, 100);
      add_lookups(60);
      // push the input while the receiver stalls
      hold_long = 1'b1;
      add_lookups(40);
      repeat (3000) @(posedge clock);
      hold_long = 1'b0;
      drain();

      write_timeout(32'd0);
      add_sweep(6, 1'b0, 2);
      add_lookups(20);
      drain();
      write_timeout(32'hFFFF_FFFF);
      add_sweep(STEPS + 2, 1'b0, 64'hFFFF_FFFF);
      add_lookups(80);
      drain();
      write_timeout(32'd500);
      add_sweep(40, 1'b0, 520);
      add_lookups(60);
      drain();
      write_timeout(cvfc_pkg::TIMEOUT_RESET);
      for (int r = 0; r < 5; r++) begin
         add_sweep($urandom_range(10, STEPS + 2), 1'b0, 200);
         add_lookups(60);
         drain();
      end
      calm = 1'b1;
      add_sweep(20, 1'b1, 100);
      add_lookups(60);
      drain();

      if (errors == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule

// ===== files.f =====
hdl/cvfc_pkg.sv
hdl/cvfc_ram.sv
hdl/cvfc_dp.sv
hdl/cvfc_ctrl.sv
hdl/cv_frequency_calibration_sweep.sv
bench/tb_cv_frequency_calibration_sweep.sv
